/* rtl/psqm_pkg.sv */
// ----------------------------------------------------------------------------
// psqm_pkg
// Shared types and codes for the process state queue manager: field widths,
// command and status codes, and the queue control bundle.
// ----------------------------------------------------------------------------
package psqm_pkg;

    // Field widths
    localparam int ID_W    = 4;
    localparam int NUM_IDS = 1 << ID_W;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 24;

    // Command codes
    localparam logic [OP_W-1:0] OP_PRE_READY   = 3'd0;
    localparam logic [OP_W-1:0] OP_PRE_RUN     = 3'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT     = 3'd2;
    localparam logic [OP_W-1:0] OP_BLOCK       = 3'd3;
    localparam logic [OP_W-1:0] OP_WAKEUP      = 3'd4;
    localparam logic [OP_W-1:0] OP_PRE_BLOCKED = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NORUN    = 3'd1;
    localparam logic [ST_W-1:0] ST_BLKEMPTY = 3'd2;
    localparam logic [ST_W-1:0] ST_USED     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    // Control bundle from the sequencer to one queue
    typedef struct packed {
        logic issue;   // read the head entry into the read register
        logic push;    // write at the tail
        logic pop;     // advance the head
    } t_q_ctl;

endpackage

/* rtl/psqm_queue.sv */
// ----------------------------------------------------------------------------
// psqm_queue
// Circular id queue held in a synchronous memory with a registered read
// port. Head, tail and fill registers track the occupied entries.
// ----------------------------------------------------------------------------
module psqm_queue #(
    parameter int NUM_PROCS = 16,
    parameter int FILL_W    = $clog2(NUM_PROCS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  psqm_pkg::t_q_ctl      i_ctl,
    input  logic [psqm_pkg::ID_W-1:0] i_push_id,
    output logic [psqm_pkg::ID_W-1:0] o_head_id,
    output logic [FILL_W-1:0]     o_fill,
    output logic                  o_empty,
    output logic                  o_full
);
    import psqm_pkg::*;

    localparam int PTR_W = $clog2(NUM_PROCS);

    logic [ID_W-1:0]  r_mem [NUM_PROCS];
    logic [ID_W-1:0]  r_rd_data;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;

    // Write at the tail, read the head into the read register
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_ctl.issue) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.pop) begin
            n_head = (r_head == PTR_W'(NUM_PROCS - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == PTR_W'(NUM_PROCS - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    assign o_head_id = r_rd_data;
    assign o_fill    = r_fill;
    assign o_empty   = (r_fill == '0);
    assign o_full    = (r_fill == FILL_W'(NUM_PROCS));

endmodule

/* rtl/psqm_ctrl.sv */
// ----------------------------------------------------------------------------
// psqm_ctrl
// Command sequencer: takes a request, reads both queue heads, then decides
// the moves, updates the running slot and the id map and loads the status.
// ----------------------------------------------------------------------------
module psqm_ctrl #(
    parameter int NUM_PROCS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command side
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  logic [psqm_pkg::OP_W-1:0] i_op,
    input  logic [psqm_pkg::ID_W-1:0] i_proc_id,
    // result side
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output logic [psqm_pkg::ST_W-1:0] o_status,
    output logic                      o_running_valid,
    output logic [psqm_pkg::ID_W-1:0] o_running_pid,
    // ready queue
    output psqm_pkg::t_q_ctl          o_rdy_ctl,
    output logic [psqm_pkg::ID_W-1:0] o_rdy_push_id,
    input  logic [psqm_pkg::ID_W-1:0] i_rdy_head,
    input  logic                      i_rdy_empty,
    input  logic                      i_rdy_full,
    // blocked queue
    output psqm_pkg::t_q_ctl          o_blk_ctl,
    output logic [psqm_pkg::ID_W-1:0] o_blk_push_id,
    input  logic [psqm_pkg::ID_W-1:0] i_blk_head,
    input  logic                      i_blk_empty,
    input  logic                      i_blk_full
);
    import psqm_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic            r_state, n_state;
    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_pid;
    logic [ST_W-1:0] r_status, n_status;
    logic            r_out_valid, n_out_valid;
    logic            r_run_busy, n_run_busy;
    logic [ID_W-1:0] r_run_slot, n_run_slot;
    logic [NUM_IDS-1:0] r_used, n_used;

    logic cmd_acc;
    logic commit;
    logic id_bad;
    logic set_used;
    logic rdy_push, rdy_pop, blk_push, blk_pop;

    assign cmd_acc = i_cmd_valid && o_cmd_ready;
    assign commit  = (r_state == S_EXEC) && (!r_out_valid || i_res_ready);
    assign id_bad  = (int'(r_pid) >= NUM_PROCS) || r_used[r_pid];

    // Hold the command for the decision cycle
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_op  <= i_op;
            r_pid <= i_proc_id;
        end
    end

    // Decide the moves from the command and the queue heads
    always_comb begin
        n_status      = ST_OK;
        n_run_busy    = r_run_busy;
        n_run_slot    = r_run_slot;
        set_used      = 1'b0;
        rdy_push      = 1'b0;
        rdy_pop       = 1'b0;
        blk_push      = 1'b0;
        blk_pop       = 1'b0;
        o_rdy_push_id = r_pid;
        o_blk_push_id = r_pid;
        unique case (r_op)
            OP_PRE_READY: begin
                if (id_bad) begin
                    n_status = ST_USED;
                end else if (i_rdy_full) begin
                    n_status = ST_FULL;
                end else begin
                    rdy_push = 1'b1;
                    set_used = 1'b1;
                end
            end
            OP_PRE_RUN: begin
                if (id_bad) begin
                    n_status = ST_USED;
                end else if (r_run_busy) begin
                    n_status = ST_FULL;
                end else begin
                    n_run_busy = 1'b1;
                    n_run_slot = r_pid;
                    set_used   = 1'b1;
                end
            end
            OP_PRE_BLOCKED: begin
                if (id_bad) begin
                    n_status = ST_USED;
                end else if (i_blk_full) begin
                    n_status = ST_FULL;
                end else begin
                    blk_push = 1'b1;
                    set_used = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                o_rdy_push_id = r_run_slot;
                if (!r_run_busy) begin
                    n_status = ST_NORUN;
                end else if (i_rdy_full) begin
                    n_status = ST_FULL;
                end else begin
                    // requeue and dispatch; an empty queue gives the same id back
                    rdy_push   = 1'b1;
                    rdy_pop    = 1'b1;
                    n_run_slot = i_rdy_empty ? r_run_slot : i_rdy_head;
                end
            end
            OP_BLOCK: begin
                o_blk_push_id = r_run_slot;
                if (!r_run_busy) begin
                    n_status = ST_NORUN;
                end else if (i_blk_full) begin
                    n_status = ST_FULL;
                end else begin
                    blk_push = 1'b1;
                    if (!i_rdy_empty) begin
                        rdy_pop    = 1'b1;
                        n_run_slot = i_rdy_head;
                    end else begin
                        n_run_busy = 1'b0;
                        n_run_slot = '0;
                    end
                end
            end
            OP_WAKEUP: begin
                o_rdy_push_id = i_blk_head;
                if (i_blk_empty) begin
                    n_status = ST_BLKEMPTY;
                end else if (i_rdy_full) begin
                    n_status = ST_FULL;
                end else begin
                    blk_pop  = 1'b1;
                    rdy_push = 1'b1;
                    // dispatch on an idle CPU; forward the woken id past an empty queue
                    if (!r_run_busy) begin
                        rdy_pop    = 1'b1;
                        n_run_busy = 1'b1;
                        n_run_slot = i_rdy_empty ? i_blk_head : i_rdy_head;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Gate queue updates with the commit; reads go out with the request
    assign o_rdy_ctl = '{issue: cmd_acc, push: rdy_push && commit, pop: rdy_pop && commit};
    assign o_blk_ctl = '{issue: cmd_acc, push: blk_push && commit, pop: blk_pop && commit};

    // Sequence: accept, then decide once the result register is free
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_used      = r_used;
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (set_used) begin
                        n_used[r_pid] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_run_busy  <= 1'b0;
            r_run_slot  <= '0;
            r_used      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_used      <= n_used;
            if (commit) begin
                r_run_busy <= n_run_busy;
                r_run_slot <= n_run_slot;
            end
        end
    end

    // Load the status with the commit
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_status <= n_status;
        end
    end

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_res_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_running_valid = r_run_busy;
    assign o_running_pid   = r_run_busy ? r_run_slot : '0;

endmodule

/* rtl/process_state_queue_manager_top.sv */
// ----------------------------------------------------------------------------
// process_state_queue_manager_top
// Three-state process tracker: ready queue, running slot, blocked queue.
//
//   Channel   Dir  Bus               Contents
//   command   in   s_axis (8 bits)   op, proc_id
//   result    out  m_axis (24 bits)  status, running_valid, running_pid,
//                                    ready_count, blocked_count
//
// A command is handled in two steps: reading both queue heads from their
// memories, then deciding and writing back; no new request is taken until
// the decision is made. The read register of each queue sets the read step.
// Reset clears pointers, fills, the running slot and the id map; queue
// memories are not cleared. A stalled result holds the decision cycle;
// the next request is still taken while a result waits.
// ----------------------------------------------------------------------------
module process_state_queue_manager_top #(
    parameter int NUM_PROCS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [psqm_pkg::IN_W-1:0]  i_s_axis_tdata,   // [2:0] op, [6:3] proc_id
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [psqm_pkg::OUT_W-1:0] o_m_axis_tdata    // [2:0] status, [3] running_valid,
                                                         // [7:4] running_pid,
                                                         // [12:8] ready_count,
                                                         // [17:13] blocked_count
);
    import psqm_pkg::*;

    localparam int FILL_W = $clog2(NUM_PROCS + 1);

    t_q_ctl            rdy_ctl, blk_ctl;
    logic [ID_W-1:0]   rdy_push_id, blk_push_id;
    logic [ID_W-1:0]   rdy_head, blk_head;
    logic [FILL_W-1:0] rdy_fill, blk_fill;
    logic              rdy_empty, rdy_full, blk_empty, blk_full;
    logic [ST_W-1:0]   status;
    logic              running_valid;
    logic [ID_W-1:0]   running_pid;

    psqm_ctrl #(.NUM_PROCS(NUM_PROCS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_s_axis_tvalid),
        .o_cmd_ready     (o_s_axis_tready),
        .i_op            (i_s_axis_tdata[OP_W-1:0]),
        .i_proc_id       (i_s_axis_tdata[OP_W+ID_W-1:OP_W]),
        .o_res_valid     (o_m_axis_tvalid),
        .i_res_ready     (i_m_axis_tready),
        .o_status        (status),
        .o_running_valid (running_valid),
        .o_running_pid   (running_pid),
        .o_rdy_ctl       (rdy_ctl),
        .o_rdy_push_id   (rdy_push_id),
        .i_rdy_head      (rdy_head),
        .i_rdy_empty     (rdy_empty),
        .i_rdy_full      (rdy_full),
        .o_blk_ctl       (blk_ctl),
        .o_blk_push_id   (blk_push_id),
        .i_blk_head      (blk_head),
        .i_blk_empty     (blk_empty),
        .i_blk_full      (blk_full)
    );

    psqm_queue #(.NUM_PROCS(NUM_PROCS), .FILL_W(FILL_W)) u_rdy_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (rdy_ctl),
        .i_push_id (rdy_push_id),
        .o_head_id (rdy_head),
        .o_fill    (rdy_fill),
        .o_empty   (rdy_empty),
        .o_full    (rdy_full)
    );

    psqm_queue #(.NUM_PROCS(NUM_PROCS), .FILL_W(FILL_W)) u_blk_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (blk_ctl),
        .i_push_id (blk_push_id),
        .o_head_id (blk_head),
        .o_fill    (blk_fill),
        .o_empty   (blk_empty),
        .o_full    (blk_full)
    );

    // Pack the result; counts stay put while a result waits
    assign o_m_axis_tdata = {
        {(OUT_W - ST_W - 1 - ID_W - 2*CNT_W){1'b0}},
        CNT_W'(blk_fill),
        CNT_W'(rdy_fill),
        running_pid,
        running_valid,
        status
    };

endmodule

/* rtl/psqm_checker.sv */
// ----------------------------------------------------------------------------
// psqm_checker
// Port-level checks of the process state queue manager, bound to the top.
// ----------------------------------------------------------------------------
module psqm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [psqm_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import psqm_pkg::*;

    logic [ST_W-1:0]  chk_status;
    logic             chk_run_valid;
    logic [ID_W-1:0]  chk_run_pid;
    logic [CNT_W+1:0] chk_total;

    assign chk_status    = o_m_axis_tdata[ST_W-1:0];
    assign chk_run_valid = o_m_axis_tdata[ST_W];
    assign chk_run_pid   = o_m_axis_tdata[ST_W+ID_W:ST_W+1];
    assign chk_total     = (CNT_W+2)'(o_m_axis_tdata[ST_W+ID_W+CNT_W:ST_W+ID_W+1])
                         + (CNT_W+2)'(o_m_axis_tdata[ST_W+ID_W+2*CNT_W:ST_W+ID_W+CNT_W+1])
                         + (CNT_W+2)'(chk_run_valid);

    // Hold a pending result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Drop ready for the decision cycle after each request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken during decision cycle");

    // Idle CPU shows a zero id
    a_idle_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !chk_run_valid |-> chk_run_pid == '0)
        else $error("running id shown while idle");

    // The tracked processes never outnumber the ids
    a_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> chk_total <= (CNT_W+2)'(NUM_IDS))
        else $error("more processes tracked than ids");

    // Nothing running is reported only with an idle CPU
    a_norun_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && chk_status == ST_NORUN |-> !chk_run_valid)
        else $error("nothing running reported while busy");

endmodule

bind process_state_queue_manager_top psqm_checker u_psqm_checker (.*);
